### hdl/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg: shared types and constants for the address region table
// Field widths, operation and status codes, sequencer states and the
// records passed between the sequencer, the slot store and the compare unit.
// ----------------------------------------------------------------------------
package art_pkg;

   // fixed field widths
   localparam int ADDR_BITS = 48;
   localparam int WORD_BITS = 32;
   localparam int SLOT_BITS = 4;

   // defaults for the top-level parameters (page size must be a power of two)
   localparam int SLOTS_DEF      = 16;
   localparam int PAGE_BYTES_DEF = 4096;

   // stream payload widths
   localparam int REQ_DATA_BITS = 256;
   localparam int REQ_USER_BITS = 2;
   localparam int RESULT_BITS   = 2 + SLOT_BITS + 3 * ADDR_BITS + 2 * WORD_BITS;
   localparam int RSP_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - RESULT_BITS;

   // configuration registers
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_BASE  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_LIMIT = 1'b1;
   localparam logic [ADDR_BITS-1:0] WINDOW_BASE_RST  = 48'h0000_4000_0000;
   localparam logic [ADDR_BITS-1:0] WINDOW_LIMIT_RST = 48'h8000_0000_0000;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_FIND   = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_FREE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_ROUND,
      ST_PASS,
      ST_SCAN,
      ST_DONE
   } state_type;

   // one stored region
   typedef struct packed {
      logic [WORD_BITS-1:0] class_word;
      logic [WORD_BITS-1:0] flags_word;
      logic [ADDR_BITS-1:0] end_addr;
      logic [ADDR_BITS-1:0] start_addr;
   } region_type;

   // one request beat, unpacked
   typedef struct packed {
      kind_type             kind;
      logic [ADDR_BITS-1:0] range_start;
      logic [ADDR_BITS-1:0] range_end;
      logic [WORD_BITS-1:0] access_flags;
      logic [WORD_BITS-1:0] region_class;
      logic [ADDR_BITS-1:0] probe_addr;
      logic [ADDR_BITS-1:0] request_bytes;
   } req_type;

   // one response beat, unpacked
   typedef struct packed {
      logic [ADDR_BITS-1:0] free_addr;
      logic [WORD_BITS-1:0] hit_class;
      logic [WORD_BITS-1:0] hit_flags;
      logic [ADDR_BITS-1:0] hit_end;
      logic [ADDR_BITS-1:0] hit_start;
      logic [SLOT_BITS-1:0] slot;
      status_type           status;
   } result_type;

   // sequencer commands to the slot store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic inv_en;
   } store_cmd_type;

endpackage

### hdl/address_region_table.sv
// ----------------------------------------------------------------------------
// address_region_table: first-fit address region table
// Stores up to SLOTS regions; add, find, remove and first-fit free-space
// search over a configurable window, one operation at a time.
//
//   channel | direction | payload
//   req_    | in        | tuser: kind; tdata: range_start .. request_bytes
//   rsp_    | out       | tdata: status, slot, hit_*, free_addr
//   csr_    | in        | window_base (0), window_limit (1), write only
//
// Each scan reads one slot a cycle through the single read port of the slot
// memory into the shared compare unit, and every restart of find free costs
// one more scan; find stops at the first hit, remove scans every slot.
// Reset clears all valid bits at once, so the table is usable the next cycle.
// A waiting response does not block a new request; a full response register
// holds the finished result inside the sequencer. The user must keep
// PAGE_BYTES a power of two; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module address_region_table #(
   parameter int SLOTS      = art_pkg::SLOTS_DEF,
   parameter int PAGE_BYTES = art_pkg::PAGE_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request beat
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // range_start, range_end, access_flags, region_class, probe_addr,
   // request_bytes (low bit up)
   input  logic [art_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // kind
   input  logic [art_pkg::REQ_USER_BITS-1:0]   req_tuser,
   // response beat
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status, slot, hit_start, hit_end, hit_flags, hit_class, free_addr,
   // zero pad (low bit up)
   output logic [art_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // configuration writes
   input  logic                                csr_wr_en,
   input  logic [art_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [art_pkg::ADDR_BITS-1:0]       csr_wdata
);
   import art_pkg::*;

   localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [ADDR_BITS-1:0]     window_base_ff, window_base_in;
   logic [ADDR_BITS-1:0]     window_limit_ff, window_limit_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;

   req_type                  req;
   logic                     req_accept;
   logic                     idle;
   logic                     res_valid;
   logic                     res_take;
   result_type               res;
   store_cmd_type            cmd;
   logic [IDX_BITS-1:0]      wr_idx;
   region_type               wr_data;
   logic [IDX_BITS-1:0]      rd_idx;
   logic [IDX_BITS-1:0]      inv_idx;
   region_type               rd_data;
   logic                     rd_live;
   logic                     free_hit;
   logic [IDX_BITS-1:0]      free_idx;

   // unpack the request beat
   assign req.kind          = kind_type'(req_tuser);
   assign req.range_start   = req_tdata[ADDR_BITS-1:0];
   assign req.range_end     = req_tdata[2*ADDR_BITS-1:ADDR_BITS];
   assign req.access_flags  = req_tdata[2*ADDR_BITS+WORD_BITS-1:2*ADDR_BITS];
   assign req.region_class  = req_tdata[2*ADDR_BITS+2*WORD_BITS-1:2*ADDR_BITS+WORD_BITS];
   assign req.probe_addr    = req_tdata[3*ADDR_BITS+2*WORD_BITS-1:2*ADDR_BITS+2*WORD_BITS];
   assign req.request_bytes = req_tdata[4*ADDR_BITS+2*WORD_BITS-1:3*ADDR_BITS+2*WORD_BITS];

   assign req_tready = idle;
   assign req_accept = req_tvalid & idle;

   // configuration registers
   always_comb begin
      window_base_in  = window_base_ff;
      window_limit_in = window_limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_BASE:  window_base_in  = csr_wdata;
            CSR_WINDOW_LIMIT: window_limit_in = csr_wdata;
            default:          window_base_in  = window_base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff  <= WINDOW_BASE_RST;
         window_limit_ff <= WINDOW_LIMIT_RST;
      end else begin
         window_base_ff  <= window_base_in;
         window_limit_ff <= window_limit_in;
      end
   end

   art_slot_store #(
      .SLOTS    (SLOTS),
      .IDX_BITS (IDX_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .wr_idx   (wr_idx),
      .wr_data  (wr_data),
      .rd_idx   (rd_idx),
      .inv_idx  (inv_idx),
      .rd_data  (rd_data),
      .rd_live  (rd_live),
      .free_hit (free_hit),
      .free_idx (free_idx)
   );

   art_seq #(
      .SLOTS      (SLOTS),
      .PAGE_BYTES (PAGE_BYTES),
      .IDX_BITS   (IDX_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_accept   (req_accept),
      .req          (req),
      .window_base  (window_base_ff),
      .window_limit (window_limit_ff),
      .idle         (idle),
      .res_valid    (res_valid),
      .res          (res),
      .res_take     (res_take),
      .cmd          (cmd),
      .wr_idx       (wr_idx),
      .wr_data      (wr_data),
      .rd_idx       (rd_idx),
      .inv_idx      (inv_idx),
      .rd_data      (rd_data),
      .rd_live      (rd_live),
      .free_hit     (free_hit),
      .free_idx     (free_idx)
   );

   // response register: load when empty or being drained
   assign res_take = res_valid & (~rsp_tvalid_ff | rsp_tready);

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (res_take) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {{RSP_PAD_BITS{1'b0}}, res};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

### hdl/art_cmp_unit.sv
// ----------------------------------------------------------------------------
// art_cmp_unit: shared compare, page-round and sum unit
// One pair of range comparators serves find, remove and the free-space
// overlap test; one page rounder and one window adder serve the free search.
// ----------------------------------------------------------------------------
module art_cmp_unit #(
   parameter int PAGE_BYTES = art_pkg::PAGE_BYTES_DEF
) (
   input  art_pkg::kind_type                mode,
   input  art_pkg::region_type              entry,
   input  logic [art_pkg::ADDR_BITS-1:0]    probe_addr,
   input  logic [art_pkg::ADDR_BITS-1:0]    range_start,
   input  logic [art_pkg::ADDR_BITS-1:0]    range_end,
   input  logic [art_pkg::ADDR_BITS-1:0]    addr,
   input  logic [art_pkg::ADDR_BITS-1:0]    size,
   input  logic [art_pkg::ADDR_BITS:0]      sum_reg,
   input  logic [art_pkg::ADDR_BITS-1:0]    limit,
   input  logic [art_pkg::ADDR_BITS-1:0]    request_bytes,
   input  logic                             round_sel,
   output logic                             match,
   output logic [art_pkg::ADDR_BITS-1:0]    round_val,
   output logic                             round_ovf,
   output logic [art_pkg::ADDR_BITS:0]      sum_val,
   output logic                             sum_fits
);
   import art_pkg::*;

   localparam logic [ADDR_BITS:0] PAGE_ADD = (ADDR_BITS + 1)'(PAGE_BYTES - 1);

   logic [ADDR_BITS-1:0] round_src;
   logic [ADDR_BITS:0]   round_sum;
   logic [ADDR_BITS:0]   round_full;
   logic [ADDR_BITS-1:0] key1;
   logic [ADDR_BITS:0]   a2;
   logic [ADDR_BITS:0]   b2;
   logic                 c1;
   logic                 c2;

   // round up to a page; a carry out means the result left the address range
   assign round_src  = round_sel ? entry.end_addr : request_bytes;
   assign round_sum  = {1'b0, round_src} + PAGE_ADD;
   assign round_full = round_sum & ~PAGE_ADD;
   assign round_val  = round_full[ADDR_BITS-1:0];
   assign round_ovf  = round_full[ADDR_BITS];

   // window adder and limit check, one bit wider so nothing wraps
   assign sum_val  = {1'b0, addr} + {1'b0, size};
   assign sum_fits = (sum_val <= {1'b0, limit});

   // steer operands into the two shared comparators
   always_comb begin
      key1 = probe_addr;
      a2   = {1'b0, probe_addr};
      b2   = {1'b0, entry.start_addr};
      case (mode)
         KIND_FIND: begin
            key1 = probe_addr;
            a2   = {1'b0, probe_addr};
            b2   = {1'b0, entry.start_addr};
         end
         KIND_REMOVE: begin
            key1 = range_end;
            a2   = {1'b0, entry.start_addr};
            b2   = {1'b0, range_start};
         end
         KIND_FREE: begin
            key1 = addr;
            a2   = {1'b0, entry.start_addr};
            b2   = sum_reg;
         end
         default: begin
            key1 = probe_addr;
         end
      endcase
   end

   assign c1 = (key1 < entry.end_addr);
   assign c2 = (a2 < b2);

   // combine comparator outputs per operation
   always_comb begin
      case (mode)
         KIND_FIND:   match = c1 & ~c2;
         KIND_REMOVE: match = ~c1 & ~c2;
         KIND_FREE:   match = c1 & c2;
         default:     match = 1'b0;
      endcase
   end

endmodule

### hdl/art_slot_store.sv
// ----------------------------------------------------------------------------
// art_slot_store: region memory with per-slot valid bits
// One write port, one registered read port, valid flops cleared by reset
// and a lowest-free-slot encoder for add.
// ----------------------------------------------------------------------------
module art_slot_store #(
   parameter int SLOTS    = art_pkg::SLOTS_DEF,
   parameter int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  art_pkg::store_cmd_type  cmd,
   input  logic [IDX_BITS-1:0]     wr_idx,
   input  art_pkg::region_type     wr_data,
   input  logic [IDX_BITS-1:0]     rd_idx,
   input  logic [IDX_BITS-1:0]     inv_idx,
   output art_pkg::region_type     rd_data,
   output logic                    rd_live,
   output logic                    free_hit,
   output logic [IDX_BITS-1:0]     free_idx
);
   import art_pkg::*;

   region_type          slot_mem_ff [SLOTS];
   region_type          rd_data_ff;
   logic                rd_live_ff;
   logic [SLOTS-1:0]    valid_ff;
   logic [SLOTS-1:0]    valid_in;

   // write port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slot_mem_ff[wr_idx] <= wr_data;
      end
   end

   // registered read port, valid bit sampled with the data
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_idx];
         rd_live_ff <= valid_ff[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_live = rd_live_ff;

   // set on add, drop on remove
   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (cmd.inv_en) begin
         valid_in[inv_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // lowest free slot
   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_hit = 1'b1;
            free_idx = IDX_BITS'(i);
         end
      end
   end

endmodule

### hdl/art_seq.sv
// ----------------------------------------------------------------------------
// art_seq: operation sequencer
// Walks the slot store one entry per cycle through the shared compare unit,
// restarts the free-space search on each overlap and stages the result.
// ----------------------------------------------------------------------------
module art_seq #(
   parameter int SLOTS      = art_pkg::SLOTS_DEF,
   parameter int PAGE_BYTES = art_pkg::PAGE_BYTES_DEF,
   parameter int IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_accept,
   input  art_pkg::req_type              req,
   input  logic [art_pkg::ADDR_BITS-1:0] window_base,
   input  logic [art_pkg::ADDR_BITS-1:0] window_limit,
   output logic                          idle,
   output logic                          res_valid,
   output art_pkg::result_type           res,
   input  logic                          res_take,
   output art_pkg::store_cmd_type        cmd,
   output logic [IDX_BITS-1:0]           wr_idx,
   output art_pkg::region_type           wr_data,
   output logic [IDX_BITS-1:0]           rd_idx,
   output logic [IDX_BITS-1:0]           inv_idx,
   input  art_pkg::region_type           rd_data,
   input  logic                          rd_live,
   input  logic                          free_hit,
   input  logic [IDX_BITS-1:0]           free_idx
);
   import art_pkg::*;

   localparam int CNT_BITS = $clog2(SLOTS + 1);
   localparam logic [CNT_BITS-1:0] SLOT_COUNT = CNT_BITS'(SLOTS);

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [CNT_BITS-1:0]  issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic [IDX_BITS-1:0]  pend_idx_ff, pend_idx_in;
   logic [CNT_BITS-1:0]  pass_ff, pass_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [ADDR_BITS-1:0] size_ff, size_in;
   logic [ADDR_BITS:0]   sum_ff, sum_in;
   result_type           res_ff, res_in;

   logic                 match;
   logic [ADDR_BITS-1:0] round_val;
   logic                 round_ovf;
   logic [ADDR_BITS:0]   sum_val;
   logic                 sum_fits;
   logic                 round_sel;
   logic                 issue_now;
   logic                 hit;
   logic                 scan_end;
   logic                 last_pass;
   logic [IDX_BITS+SLOT_BITS-1:0] free_slot_wide;
   logic [IDX_BITS+SLOT_BITS-1:0] hit_slot_wide;

   art_cmp_unit #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_cmp (
      .mode          (req_ff.kind),
      .entry         (rd_data),
      .probe_addr    (req_ff.probe_addr),
      .range_start   (req_ff.range_start),
      .range_end     (req_ff.range_end),
      .addr          (addr_ff),
      .size          (size_ff),
      .sum_reg       (sum_ff),
      .limit         (window_limit),
      .request_bytes (req_ff.request_bytes),
      .round_sel     (round_sel),
      .match         (match),
      .round_val     (round_val),
      .round_ovf     (round_ovf),
      .sum_val       (sum_val),
      .sum_fits      (sum_fits)
   );

   // scan status: a read is issued while slots remain, compared in the next cycle
   assign issue_now = (issue_ff < SLOT_COUNT);
   assign hit       = pend_ff & rd_live & match;
   assign scan_end  = ~issue_now & ~pend_ff;
   assign last_pass = (pass_ff == SLOT_COUNT);
   assign round_sel = (state_ff == ST_SCAN);

   // slot number as reported, masked to the field width
   assign free_slot_wide = {{SLOT_BITS{1'b0}}, free_idx};
   assign hit_slot_wide  = {{SLOT_BITS{1'b0}}, pend_idx_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req.kind)
                  KIND_ADD:    state_in = ST_ADD;
                  KIND_FIND:   state_in = ST_SCAN;
                  KIND_REMOVE: state_in = ST_SCAN;
                  KIND_FREE:   state_in = ST_ROUND;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            state_in = ST_DONE;
         end
         ST_ROUND: begin
            state_in = round_ovf ? ST_DONE : ST_PASS;
         end
         ST_PASS: begin
            state_in = sum_fits ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            case (req_ff.kind)
               KIND_FIND: begin
                  if (hit || scan_end) begin
                     state_in = ST_DONE;
                  end
               end
               KIND_REMOVE: begin
                  if (scan_end) begin
                     state_in = ST_DONE;
                  end
               end
               KIND_FREE: begin
                  if (hit) begin
                     state_in = (round_ovf || last_pass) ? ST_DONE : ST_PASS;
                  end else if (scan_end) begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath updates and store commands
   always_comb begin
      req_in      = req_ff;
      issue_in    = issue_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      pass_in     = pass_ff;
      addr_in     = addr_ff;
      size_in     = size_ff;
      sum_in      = sum_ff;
      res_in      = res_ff;
      cmd         = '0;
      wr_idx      = free_idx;
      rd_idx      = issue_ff[IDX_BITS-1:0];
      inv_idx     = pend_idx_ff;
      idle        = 1'b0;
      res_valid   = 1'b0;
      wr_data.start_addr = req_ff.range_start;
      wr_data.end_addr   = req_ff.range_end;
      wr_data.flags_word = req_ff.access_flags;
      wr_data.class_word = req_ff.region_class;
      case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (req_accept) begin
               req_in   = req;
               issue_in = '0;
               pend_in  = 1'b0;
            end
         end
         ST_ADD: begin
            cmd.wr_en = free_hit;
            res_in    = '0;
            if (free_hit) begin
               res_in.status = STATUS_OK;
               res_in.slot   = free_slot_wide[SLOT_BITS-1:0];
            end else begin
               res_in.status = STATUS_FULL;
            end
         end
         ST_ROUND: begin
            size_in = round_val;
            addr_in = window_base;
            pass_in = '0;
            res_in  = '0;
            if (round_ovf) begin
               res_in.status = STATUS_MISS;
            end
         end
         ST_PASS: begin
            sum_in   = sum_val;
            issue_in = '0;
            pend_in  = 1'b0;
            if (!sum_fits) begin
               res_in        = '0;
               res_in.status = STATUS_MISS;
            end
         end
         ST_SCAN: begin
            // advance the read pointer
            cmd.rd_en   = issue_now;
            pend_in     = issue_now;
            pend_idx_in = issue_ff[IDX_BITS-1:0];
            if (issue_now) begin
               issue_in = issue_ff + CNT_BITS'(1);
            end
            case (req_ff.kind)
               KIND_FIND: begin
                  if (hit) begin
                     res_in           = '0;
                     res_in.status    = STATUS_OK;
                     res_in.slot      = hit_slot_wide[SLOT_BITS-1:0];
                     res_in.hit_start = rd_data.start_addr;
                     res_in.hit_end   = rd_data.end_addr;
                     res_in.hit_flags = rd_data.flags_word;
                     res_in.hit_class = rd_data.class_word;
                  end else if (scan_end) begin
                     res_in        = '0;
                     res_in.status = STATUS_MISS;
                  end
               end
               KIND_REMOVE: begin
                  cmd.inv_en = hit;
                  if (scan_end) begin
                     res_in = '0;
                  end
               end
               KIND_FREE: begin
                  if (hit) begin
                     // restart past the overlapping region
                     addr_in = round_val;
                     pass_in = pass_ff + CNT_BITS'(1);
                     if (round_ovf || last_pass) begin
                        res_in        = '0;
                        res_in.status = STATUS_MISS;
                     end
                  end else if (scan_end) begin
                     res_in           = '0;
                     res_in.status    = STATUS_OK;
                     res_in.free_addr = addr_ff;
                  end
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end
         ST_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
            idle = 1'b0;
         end
      endcase
   end

   assign res = res_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         issue_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         issue_ff <= issue_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pend_idx_ff <= pend_idx_in;
      pass_ff     <= pass_in;
      addr_ff     <= addr_in;
      size_ff     <= size_in;
      sum_ff      <= sum_in;
      res_ff      <= res_in;
   end

endmodule

### tb/region_table_checker.sv
// ----------------------------------------------------------------------------
// region_table_checker: response predictor and comparator
// Watches the request, response and register-write ports of the address
// region table, keeps its own copy of the slot table and the search window,
// predicts one response per request beat and compares it field by field.
// ----------------------------------------------------------------------------
module region_table_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [art_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic [art_pkg::REQ_USER_BITS-1:0]  req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [art_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [art_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [art_pkg::ADDR_BITS-1:0]      csr_wdata,
   input  logic                               run_done,
   output int                                 fail_count
);
   import art_pkg::*;

   localparam int SLOTS = SLOTS_DEF;
   localparam int PAGE  = PAGE_BYTES_DEF;

   logic [ADDR_BITS-1:0] win_base;
   logic [ADDR_BITS-1:0] win_limit;
   logic                 slot_used [SLOTS];
   region_type           slot_tab  [SLOTS];
   result_type           pending_results [$];
   result_type           got_rsp;
   result_type           want_rsp;
   int                   mismatches;
   logic                 closed;

   assign fail_count = mismatches;

   // round up to a page multiple; 64 bits leave room above the address range
   function automatic logic [63:0] page_up(input logic [63:0] x);
      return (x + 64'(PAGE - 1)) & ~64'(PAGE - 1);
   endfunction

   // apply one request to the table copy and work out its response
   function automatic result_type predict_region_op(
      input kind_type             kind,
      input logic [ADDR_BITS-1:0] rs,
      input logic [ADDR_BITS-1:0] re,
      input logic [WORD_BITS-1:0] fl,
      input logic [WORD_BITS-1:0] cl,
      input logic [ADDR_BITS-1:0] pa,
      input logic [ADDR_BITS-1:0] rb
   );
      result_type  res;
      logic [63:0] need;
      logic [63:0] addr;
      logic        hit;
      logic        done;
      logic        placed;
      int          i;
      int          pass;
      res    = '0;
      done   = 1'b0;
      placed = 1'b0;
      case (kind)
         KIND_ADD: begin
            res.status = STATUS_FULL;
            for (i = 0; i < SLOTS && !done; i++) begin
               if (!slot_used[i]) begin
                  slot_used[i]            = 1'b1;
                  slot_tab[i].start_addr  = rs;
                  slot_tab[i].end_addr    = re;
                  slot_tab[i].flags_word  = fl;
                  slot_tab[i].class_word  = cl;
                  res.status              = STATUS_OK;
                  res.slot                = SLOT_BITS'(i);
                  done                    = 1'b1;
               end
            end
         end
         KIND_FIND: begin
            res.status = STATUS_MISS;
            for (i = 0; i < SLOTS && !done; i++) begin
               if (slot_used[i] && pa >= slot_tab[i].start_addr &&
                   pa < slot_tab[i].end_addr) begin
                  res.status    = STATUS_OK;
                  res.slot      = SLOT_BITS'(i);
                  res.hit_start = slot_tab[i].start_addr;
                  res.hit_end   = slot_tab[i].end_addr;
                  res.hit_flags = slot_tab[i].flags_word;
                  res.hit_class = slot_tab[i].class_word;
                  done          = 1'b1;
               end
            end
         end
         KIND_REMOVE: begin
            for (i = 0; i < SLOTS; i++) begin
               if (slot_used[i] && slot_tab[i].start_addr >= rs &&
                   slot_tab[i].end_addr <= re)
                  slot_used[i] = 1'b0;
            end
         end
         default: begin
            // first fit: restart past each overlapping region, at most SLOTS+1 passes
            need = page_up({16'b0, rb});
            addr = {16'b0, win_base};
            for (pass = 0; pass <= SLOTS && !done; pass++) begin
               if (addr + need > {16'b0, win_limit}) begin
                  done = 1'b1;
               end else begin
                  hit = 1'b0;
                  for (i = 0; i < SLOTS && !hit; i++) begin
                     if (slot_used[i] && addr < {16'b0, slot_tab[i].end_addr} &&
                         addr + need > {16'b0, slot_tab[i].start_addr}) begin
                        addr = page_up({16'b0, slot_tab[i].end_addr});
                        hit  = 1'b1;
                     end
                  end
                  if (!hit) begin
                     placed = 1'b1;
                     done   = 1'b1;
                  end
               end
            end
            if (placed)
               res.free_addr = addr[ADDR_BITS-1:0];
            else
               res.status = STATUS_MISS;
         end
      endcase
      return res;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // track register writes, compare response beats, predict request beats
   always @(posedge clock) begin
      if (reset) begin
         win_base   = WINDOW_BASE_RST;
         win_limit  = WINDOW_LIMIT_RST;
         mismatches = 0;
         closed     = 1'b0;
         pending_results.delete();
         for (int i = 0; i < SLOTS; i++)
            slot_used[i] = 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WINDOW_BASE:  win_base  = csr_wdata;
               CSR_WINDOW_LIMIT: win_limit = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = result_type'(rsp_tdata[RESULT_BITS-1:0]);
            if (pending_results.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatches++;
            end else begin
               want_rsp = pending_results.pop_front();
               check_field("status",    want_rsp.status,    got_rsp.status);
               check_field("slot",      want_rsp.slot,      got_rsp.slot);
               check_field("hit_start", want_rsp.hit_start, got_rsp.hit_start);
               check_field("hit_end",   want_rsp.hit_end,   got_rsp.hit_end);
               check_field("hit_flags", want_rsp.hit_flags, got_rsp.hit_flags);
               check_field("hit_class", want_rsp.hit_class, got_rsp.hit_class);
               check_field("free_addr", want_rsp.free_addr, got_rsp.free_addr);
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(predict_region_op(kind_type'(req_tuser),
               req_tdata[47:0], req_tdata[95:48], req_tdata[127:96],
               req_tdata[159:128], req_tdata[207:160], req_tdata[255:208]));
         // anything still outstanding at the close of the run is lost
         if (run_done && !closed) begin
            closed = 1'b1;
            if (pending_results.size() != 0) begin
               $error("%0d responses never arrived", pending_results.size());
               mismatches += pending_results.size();
            end
         end
      end
   end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus for the address region table
// Drives add, find, remove and free-space requests under several search
// windows with random idling on both streams, a long response hold-off and
// drain pauses; a separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
   import art_pkg::*;

   localparam int PAGE        = PAGE_BYTES_DEF;
   localparam int RING        = 8;
   localparam int LONG_HOLD   = 80;
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 400;
   localparam logic [ADDR_BITS-1:0] ADDR_MAX = {ADDR_BITS{1'b1}};

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata  = '0;
   logic [REQ_USER_BITS-1:0]  req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_wr_en  = 1'b0;
   logic [CSR_IDX_BITS-1:0]   csr_index  = '0;
   logic [ADDR_BITS-1:0]      csr_wdata  = '0;
   logic                      run_done   = 1'b0;
   logic                      steady     = 1'b0;
   logic                      hold_req   = 1'b0;
   logic                      hold_ack;
   int                        fail_count;

   int                        sent_count = 0;
   int                        rsp_count;
   int                        tx_pct     = 0;
   int                        rx_pct;
   int                        rx_cycle;
   int                        stall_left;
   int                        no_beat_cycles;
   logic [ADDR_BITS-1:0]      cur_base   = WINDOW_BASE_RST;
   logic [ADDR_BITS-1:0]      ring_start [RING];
   logic [ADDR_BITS-1:0]      ring_end   [RING];
   int                        ring_wr    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   address_region_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   region_table_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .run_done   (run_done),
      .fail_count (fail_count)
   );

   function automatic logic [ADDR_BITS-1:0] rand48();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[ADDR_BITS-1:0];
   endfunction

   // idle rate for a stretch: none, light or heavy
   function automatic int pick_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 20;
         default: return 50;
      endcase
   endfunction

   // address a whole number of pages above the window base, sometimes unaligned
   function automatic logic [ADDR_BITS-1:0] near_addr();
      logic [ADDR_BITS-1:0] off;
      off = ADDR_BITS'(PAGE * $urandom_range(0, 31));
      if ($urandom_range(0, 3) == 0)
         off += ADDR_BITS'($urandom_range(0, PAGE - 1));
      return cur_base + off;
   endfunction

   // response side: random stall bursts, long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         hold_ack   <= 1'b0;
         rsp_count  <= 0;
         rx_cycle   <= 0;
         rx_pct     <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle % 128 == 0)
            rx_pct <= pick_pct();
         if (rsp_tvalid && rsp_tready)
            rsp_count <= rsp_count + 1;
         if (hold_req != hold_ack) begin
            hold_ack   <= hold_req;
            stall_left <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!steady && $urandom_range(0, 99) < rx_pct) begin
            stall_left <= $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         no_beat_cycles <= 0;
      end else if (no_beat_cycles == STALL_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         no_beat_cycles <= no_beat_cycles + 1;
      end
   end

   // offer one request beat, with an optional idle burst first
   task automatic send_req(
      input kind_type             kind,
      input logic [ADDR_BITS-1:0] rs,
      input logic [ADDR_BITS-1:0] re,
      input logic [WORD_BITS-1:0] fl,
      input logic [WORD_BITS-1:0] cl,
      input logic [ADDR_BITS-1:0] pa,
      input logic [ADDR_BITS-1:0] rb
   );
      int gap;
      gap = 0;
      if (sent_count % 32 == 0)
         tx_pct = pick_pct();
      if (!steady && $urandom_range(0, 99) < tx_pct)
         gap = $urandom_range(1, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {rb, pa, cl, fl, re, rs};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // hold off requests until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (rsp_count != sent_count) @(posedge clock);
   endtask

   // write both window registers on back-to-back cycles; table must be idle
   task automatic set_window(input logic [ADDR_BITS-1:0] base,
                             input logic [ADDR_BITS-1:0] limit);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WINDOW_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_WINDOW_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_base  = base;
   endtask

   // clear the table, then probe the empty window with zero, one and max sizes
   task automatic window_probe();
      send_req(KIND_REMOVE, '0, ADDR_MAX, $urandom, $urandom, rand48(), rand48());
      send_req(KIND_FREE, rand48(), rand48(), $urandom, $urandom, rand48(), '0);
      send_req(KIND_FREE, rand48(), rand48(), $urandom, $urandom, rand48(), 48'd1);
      send_req(KIND_FREE, rand48(), rand48(), $urandom, $urandom, rand48(), ADDR_MAX);
   endtask

   // one random request, mostly well-formed regions around the window base
   task automatic random_item();
      int                   sel;
      int                   pick;
      logic [ADDR_BITS-1:0] rs;
      logic [ADDR_BITS-1:0] re;
      logic [ADDR_BITS-1:0] pa;
      logic [ADDR_BITS-1:0] rb;
      logic [ADDR_BITS-1:0] span;
      kind_type             kind;
      sel  = $urandom_range(0, 99);
      pick = $urandom_range(0, RING - 1);
      rs   = near_addr();
      if ($urandom_range(0, 7) == 0)
         span = rand48();
      else
         span = ADDR_BITS'(PAGE * $urandom_range(0, 6) + $urandom_range(0, PAGE - 1));
      re = rs + span;
      // swap now and then for an inverted range
      if ($urandom_range(0, 15) == 0)
         {rs, re} = {re, rs};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: pa = ring_start[pick] + ADDR_BITS'($urandom_range(0, 2 * PAGE));
         6:                pa = ring_end[pick];
         7:                pa = near_addr();
         default:          pa = rand48();
      endcase
      case ($urandom_range(0, 9))
         0:       rb = '0;
         1:       rb = rand48();
         2:       rb = ADDR_BITS'(PAGE * $urandom_range(1, 8));
         default: rb = ADDR_BITS'($urandom_range(1, 5 * PAGE));
      endcase
      if (sel < 35) begin
         kind = KIND_ADD;
         ring_start[ring_wr] = rs;
         ring_end[ring_wr]   = re;
         ring_wr = (ring_wr + 1) % RING;
      end else if (sel < 65) begin
         kind = KIND_FIND;
      end else if (sel < 78) begin
         kind = KIND_REMOVE;
         case ($urandom_range(0, 9))
            0: begin
               rs = '0;
               re = ADDR_MAX;
            end
            1, 2, 3, 4, 5, 6: begin
               rs = ring_start[pick];
               re = ring_end[pick];
            end
            default: ;
         endcase
      end else begin
         kind = KIND_FREE;
      end
      send_req(kind, rs, re, $urandom, $urandom, pa, rb);
   endtask

   initial begin
      logic [ADDR_BITS-1:0] b;
      logic [ADDR_BITS-1:0] lim;
      logic [ADDR_BITS-1:0] rs;
      for (int i = 0; i < RING; i++) begin
         ring_start[i] = '0;
         ring_end[i]   = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, reset window
      b = WINDOW_BASE_RST;
      send_req(KIND_FIND,   rand48(), rand48(), $urandom, $urandom, '0, rand48());
      send_req(KIND_FREE,   rand48(), rand48(), $urandom, $urandom, rand48(), '0);
      send_req(KIND_FREE,   rand48(), rand48(), $urandom, $urandom, rand48(), ADDR_MAX);
      send_req(KIND_ADD,    b, b + 48'h1800, '1, '1, rand48(), rand48());
      // overlap at the base pushes the gap to the next page past the region
      send_req(KIND_FREE,   rand48(), rand48(), $urandom, $urandom, rand48(), 48'd1);
      send_req(KIND_FIND,   rand48(), rand48(), $urandom, $urandom, b, rand48());
      send_req(KIND_FIND,   rand48(), rand48(), $urandom, $urandom, b + 48'h1800, rand48());
      // inverted range never matches
      send_req(KIND_ADD,    ADDR_MAX, '0, '0, '0, rand48(), rand48());
      send_req(KIND_ADD,    '0, ADDR_MAX, 32'h5A5A_5A5A, 32'hA5A5_A5A5, rand48(), rand48());
      send_req(KIND_FIND,   rand48(), rand48(), $urandom, $urandom, '0, rand48());
      // restart past the top of the address range: no space
      send_req(KIND_FREE,   rand48(), rand48(), $urandom, $urandom, rand48(), '0);
      repeat (13) begin
         rs = near_addr();
         send_req(KIND_ADD, rs, rs + ADDR_BITS'($urandom_range(1, 3 * PAGE)),
                  $urandom, $urandom, rand48(), rand48());
      end
      // table full
      send_req(KIND_ADD,    near_addr(), rand48(), $urandom, $urandom, rand48(), rand48());
      send_req(KIND_REMOVE, '0, ADDR_MAX, $urandom, $urandom, rand48(), rand48());
      repeat (140) random_item();

      // whole address range; long response hold-off while requests keep coming
      set_window('0, ADDR_MAX);
      window_probe();
      send_req(KIND_ADD,  '0, 48'h1000, $urandom, $urandom, rand48(), rand48());
      send_req(KIND_FREE, rand48(), rand48(), $urandom, $urandom, rand48(), '0);
      send_req(KIND_FREE, rand48(), rand48(), $urandom, $urandom, rand48(), 48'd1);
      hold_req <= ~hold_req;
      repeat (150) random_item();

      // empty window at zero
      set_window('0, '0);
      window_probe();
      repeat (40) random_item();

      // window pinned at the top address
      set_window(ADDR_MAX, ADDR_MAX);
      window_probe();
      repeat (40) random_item();

      // narrow window: many regions inside it, many restarts
      set_window(48'h1_0000, 48'h8_0000);
      window_probe();
      repeat (120) random_item();
      drain();
      repeat (130) random_item();

      // random window
      b = rand48();
      b = b >> $urandom_range(0, 40);
      lim = b + ADDR_BITS'($urandom_range(PAGE, 64 * PAGE));
      set_window(b, lim);
      window_probe();
      repeat (150) random_item();

      // back to the reset window, no idling to the end
      set_window(WINDOW_BASE_RST, WINDOW_LIMIT_RST);
      steady <= 1'b1;
      window_probe();
      repeat (100) random_item();

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
